FILE: src/bhd_pkg.sv
// Shared constants, register codes and reset tables for the beam hold debounce block.
package bhd_pkg;

   localparam int NOTE_REGS      = 7;
   localparam int MAX_BEAMS      = 16;
   localparam int RAW_BITS       = 7;
   localparam int NOTE_BITS      = 7;
   localparam int VEL_BITS       = 7;
   localparam int IDX_BITS       = 3;
   localparam int HOLD_BITS      = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TICKS = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTE_BASE  = 4'd1;

   localparam logic [HOLD_BITS-1:0] HOLD_RESET  = 16'd16;
   localparam logic [VEL_BITS-1:0]  VELOCITY_ON = 7'd120;
   localparam logic [VEL_BITS-1:0]  VELOCITY_OFF = 7'd0;

   function automatic logic [NOTE_BITS-1:0] note_reset(input int beam);
      logic [NOTE_BITS-1:0] n;
      case (beam)
         0:       n = 7'd60;
         1:       n = 7'd62;
         2:       n = 7'd64;
         3:       n = 7'd65;
         4:       n = 7'd67;
         5:       n = 7'd69;
         6:       n = 7'd71;
         default: n = 7'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: src/bhd_lane.sv
// One beam lane: saturating tick counter, hold qualification and change detect.
module bhd_lane
   import bhd_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 raw,
   input  logic [HOLD_BITS-1:0] hold,
   output logic                 changed,
   output logic                 status
);

   localparam int CMP_BITS = (COUNT_BITS > HOLD_BITS) ? COUNT_BITS : HOLD_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  active_ff;
   logic [CMP_BITS-1:0]   count_ext, hold_ext;

   // raw hit clears then counts once, so the count lands at one
   always_comb begin
      if (raw) begin
         count_in = COUNT_BITS'(1);
      end else if (count_ff != COUNT_MAX) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign count_ext = CMP_BITS'(count_in);
   assign hold_ext  = CMP_BITS'(hold);
   assign status    = raw | (count_ext < hold_ext);
   assign changed   = status ^ active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_MAX;
         active_ff <= 1'b0;
      end else if (accept) begin
         count_ff  <= count_in;
         active_ff <= status;
      end
   end

endmodule

FILE: src/bhd_events.sv
// Merge stage: holds one tick's change mask and emits one note event per cycle while rsp_stall is low.
module bhd_events
   import bhd_pkg::*;
#(
   parameter int BEAMS = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [BEAMS-1:0]     changed,
   input  logic [BEAMS-1:0]     status,
   input  logic [NOTE_BITS-1:0] notes [BEAMS],
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_BITS-1:0]  rsp_beam_index,
   output logic [NOTE_BITS-1:0] rsp_note,
   output logic [VEL_BITS-1:0]  rsp_velocity,
   output logic                 rsp_last
);

   logic [BEAMS-1:0]     pend_ff, pend_in;
   logic [BEAMS-1:0]     stat_ff;
   logic [BEAMS-1:0]     pick;
   logic                 advance;
   logic                 valid_ff;
   logic [IDX_BITS-1:0]  idx_ff, idx_sel;
   logic [NOTE_BITS-1:0] note_ff, note_sel;
   logic [VEL_BITS-1:0]  vel_ff;
   logic                 last_ff;
   logic                 on_sel;

   // lowest pending beam goes first
   assign pick    = pend_ff & (~pend_ff + BEAMS'(1));
   assign pend_in = pend_ff & ~pick;
   assign advance = (|pend_ff) && (!valid_ff || !rsp_stall);
   assign busy    = |pend_ff;

   always_comb begin
      idx_sel  = '0;
      note_sel = '0;
      on_sel   = 1'b0;
      for (int i = 0; i < BEAMS; i++) begin
         if (pick[i]) begin
            idx_sel  = idx_sel | IDX_BITS'(i);
            note_sel = note_sel | notes[i];
            on_sel   = on_sel | stat_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            pend_ff <= changed;
         end else if (advance) begin
            pend_ff <= pend_in;
         end
         if (advance) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stat_ff <= status;
      end
      if (advance) begin
         idx_ff  <= idx_sel;
         note_ff <= note_sel;
         vel_ff  <= on_sel ? VELOCITY_ON : VELOCITY_OFF;
         last_ff <= (pend_in == '0);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_beam_index = idx_ff;
   assign rsp_note       = note_ff;
   assign rsp_velocity   = vel_ff;
   assign rsp_last       = last_ff;

   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> (pend_ff == '0))
      else $error("tick loaded over pending events");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (advance && (pend_in == '0)) |=> (pend_ff == '0) && rsp_last)
      else $error("last flag does not match empty mask");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> (pend_ff != '0))
      else $error("non-last event without pending follower");

   a_pick_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pick))
      else $error("more than one beam picked");

endmodule

FILE: src/beam_hold_debounce_note_events.sv
// Top level of the beam hold debounce block with note event output.
//
// Each request is one sample tick carrying raw beam bits (1 = interrupted).
// All beam lanes update together in the cycle the request is accepted; every
// beam whose qualified status changed then yields one note event, lowest beam
// first, one event per cycle while rsp_stall is low, from the merge stage's
// output register, with rsp_last set on the tick's final event. A tick with
// no changes yields nothing. The next request is taken as soon as the merge
// stage has moved its last pending event into the output register, even while
// that event is still stalled. Configuration (csr_index 0 = hold_ticks, 1..7 =
// note of beam 0..6) is to be written by the user only while idle; the block
// itself does not enforce this. Writes to other indexes are ignored.
module beam_hold_debounce_note_events
   import bhd_pkg::*;
#(
   parameter int BEAMS      = 7,
   parameter int COUNT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration write port
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   // tick requests
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [RAW_BITS-1:0]       req_beam_bits,
   // note events
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [IDX_BITS-1:0]       rsp_beam_index,
   output logic [NOTE_BITS-1:0]      rsp_note,
   output logic [VEL_BITS-1:0]       rsp_velocity,
   output logic                      rsp_last
);

   logic [HOLD_BITS-1:0] hold_ff;
   logic [NOTE_BITS-1:0] note_ff [BEAMS];
   logic [BEAMS-1:0]     raw;
   logic [BEAMS-1:0]     changed;
   logic [BEAMS-1:0]     status;
   logic                 accept;
   logic                 busy;

   // request is held off while the merge stage still has events to send
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_RESET;
      end else if (csr_write && (csr_index == CSR_HOLD_TICKS)) begin
         hold_ff <= csr_data[HOLD_BITS-1:0];
      end
   end

   for (genvar b = 0; b < BEAMS; b++) begin : g_beam
      // beams past the raw field never trigger; beams past the note
      // registers play note zero
      if (b < RAW_BITS) begin : g_raw
         assign raw[b] = req_beam_bits[b];
      end else begin : g_noraw
         assign raw[b] = 1'b0;
      end

      if (b < NOTE_REGS) begin : g_note
         always_ff @(posedge clock) begin
            if (reset) begin
               note_ff[b] <= note_reset(b);
            end else if (csr_write &&
                         (csr_index == CSR_NOTE_BASE + CSR_INDEX_BITS'(b))) begin
               note_ff[b] <= csr_data[NOTE_BITS-1:0];
            end
         end
      end else begin : g_nonote
         assign note_ff[b] = '0;
      end

      bhd_lane #(
         .COUNT_BITS(COUNT_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (accept),
         .raw    (raw[b]),
         .hold   (hold_ff),
         .changed(changed[b]),
         .status (status[b])
      );
   end

   bhd_events #(
      .BEAMS(BEAMS)
   ) u_events (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .changed       (changed),
      .status        (status),
      .notes         (note_ff),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_beam_index(rsp_beam_index),
      .rsp_note      (rsp_note),
      .rsp_velocity  (rsp_velocity),
      .rsp_last      (rsp_last)
   );

endmodule
